### rtl/core/bitmap_next_bit_allocator_unit_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef BITMAP_NEXT_BIT_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_NEXT_BIT_ALLOCATOR_UNIT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define BNBA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The condition must hold in the cycle after the trigger.
`define BNBA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/bnba_pkg.sv
package bnba_pkg;

   // Bitmap geometry.
   localparam int WORD_BITS = 32;
   localparam int BIDX_W    = $clog2(WORD_BITS);
   localparam int MAX_WORDS = 1024;
   localparam int WIDX_W    = $clog2(MAX_WORDS);
   localparam int WCNT_W    = WIDX_W + 1;

   // Field widths fixed by the interface.
   localparam int START_W = 15;
   localparam int POS_W   = 16;
   localparam int CFG_W   = 11;
   localparam int TYPE_W  = 2;

   // Request types.
   localparam logic [TYPE_W-1:0] REQ_FIND_SET = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_FIND_CLR = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_ALLOC    = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_LOAD     = 2'd3;

   // Configuration register map.
   localparam int                CSR_ADDR_W    = 3;
   localparam int                CSR_DATA_W    = 32;
   localparam logic              CSR_IDX_WORDS = 1'b0;
   localparam logic [CFG_W-1:0]  WORDS_RESET   = 11'd1024;

   // One write into the bitmap store.
   typedef struct packed {
      logic                 en;
      logic [WIDX_W-1:0]    addr;
      logic [WORD_BITS-1:0] data;
   } bnba_wr_type;

   // Controls for the find-first unit.
   typedef struct packed {
      logic              invert;
      logic              mask_en;
      logic [BIDX_W-1:0] shift;
   } bnba_ffs_ctl_type;

   // Answer of the find-first unit.
   typedef struct packed {
      logic                 hit;
      logic [BIDX_W-1:0]    idx;
      logic [WORD_BITS-1:0] onehot;
   } bnba_hit_type;

   // Sequencer status.
   typedef struct packed {
      logic clearing;
      logic set_wr;
   } bnba_stat_type;

endpackage

### rtl/core/bnba_if.sv
// Request channel.
interface bnba_req_if;
   logic                          valid;
   logic                          ready;
   logic [bnba_pkg::TYPE_W-1:0]   req_type;
   logic [bnba_pkg::START_W-1:0]  start_pos;
   logic [bnba_pkg::WIDX_W-1:0]   word_index;
   logic [bnba_pkg::WORD_BITS-1:0] word_data;

   modport source (output valid, req_type, start_pos, word_index, word_data, input ready);
   modport sink   (input valid, req_type, start_pos, word_index, word_data, output ready);
endinterface

// Response channel.
interface bnba_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        found;
   logic [bnba_pkg::POS_W-1:0]  bit_position;

   modport source (output valid, found, bit_position, input ready);
   modport sink   (input valid, found, bit_position, output ready);
endinterface

### rtl/core/bnba_ram.sv
// Bitmap store: one write port and one registered read port.
module bnba_ram (
   input  logic                            clock,
   input  bnba_pkg::bnba_wr_type           wr,
   input  logic                            rd_en,
   input  logic [bnba_pkg::WIDX_W-1:0]     rd_addr,
   output logic [bnba_pkg::WORD_BITS-1:0]  rd_data
);

   logic [bnba_pkg::WORD_BITS-1:0] mem [bnba_pkg::MAX_WORDS];
   logic [bnba_pkg::WORD_BITS-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Read port with registered data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/bnba_ffs.sv
// Find-first unit: finds the lowest matching bit of one word.
module bnba_ffs (
   input  logic [bnba_pkg::WORD_BITS-1:0] data,
   input  bnba_pkg::bnba_ffs_ctl_type     ctl,
   output bnba_pkg::bnba_hit_type         res
);

   logic [bnba_pkg::WORD_BITS-1:0] v;
   logic [bnba_pkg::WORD_BITS-1:0] low;
   logic [bnba_pkg::BIDX_W-1:0]    idx;

   // Invert for a clear-bit search, and drop bits below the start in the first word.
   always_comb begin
      v = ctl.invert ? ~data : data;
      if (ctl.mask_en) begin
         v = v & ({bnba_pkg::WORD_BITS{1'b1}} << ctl.shift);
      end
      low = v & (~v + bnba_pkg::WORD_BITS'(1));
   end

   // Encode the isolated lowest bit.
   always_comb begin
      idx = '0;
      for (int i = 0; i < bnba_pkg::WORD_BITS; i++) begin
         if (low[i]) begin
            idx = idx | bnba_pkg::BIDX_W'(i);
         end
      end
   end

   assign res.hit    = |v;
   assign res.idx    = idx;
   assign res.onehot = low;

endmodule

### rtl/core/bnba_ctrl.sv
// Sequencer: clearing pass, load write, word-by-word scan, allocation write and response register.
module bnba_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   bnba_req_if.sink                        req,
   bnba_rsp_if.source                      rsp,
   input  logic [bnba_pkg::WCNT_W-1:0]     limit,
   input  logic [bnba_pkg::WORD_BITS-1:0]  rd_data,
   input  bnba_pkg::bnba_hit_type          hit,
   output logic                            rd_en,
   output logic [bnba_pkg::WIDX_W-1:0]     rd_addr,
   output bnba_pkg::bnba_wr_type           wr,
   output bnba_pkg::bnba_ffs_ctl_type      ffs_ctl,
   output bnba_pkg::bnba_stat_type         stat
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]                    state_ff, state_in;
   logic [bnba_pkg::WIDX_W-1:0]   clr_ff, clr_in;
   logic [bnba_pkg::WCNT_W-1:0]   word_ff, word_in;
   logic [bnba_pkg::WIDX_W-1:0]   chk_ff, chk_in;
   logic                          chk_vld_ff, chk_vld_in;
   logic                          first_ff, first_in;
   logic [bnba_pkg::BIDX_W-1:0]   shift_ff, shift_in;
   logic [bnba_pkg::TYPE_W-1:0]   kind_ff, kind_in;
   logic                          found_ff, found_in;
   logic [bnba_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic                          rsp_vld_ff, rsp_vld_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic [bnba_pkg::POS_W-1:0]    rsp_pos_ff, rsp_pos_in;
   logic                          accept;
   logic [bnba_pkg::WCNT_W-1:0]   start_word;

   assign req.ready  = (state_ff == ST_IDLE);
   assign accept     = req.valid && req.ready;
   assign start_word = bnba_pkg::WCNT_W'(req.start_pos[bnba_pkg::START_W-1:bnba_pkg::BIDX_W]);

   // Next-state logic.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      word_in      = word_ff;
      chk_in       = chk_ff;
      chk_vld_in   = chk_vld_ff;
      first_in     = first_ff;
      shift_in     = shift_ff;
      kind_in      = kind_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp.ready;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      wr           = '0;
      stat         = '0;
      rd_en        = 1'b0;
      rd_addr      = word_ff[bnba_pkg::WIDX_W-1:0];

      unique case (state_ff)
         ST_CLEAR: begin
            stat.clearing = 1'b1;
            wr.en         = 1'b1;
            wr.addr       = clr_ff;
            clr_in        = clr_ff + 1'b1;
            if (clr_ff == bnba_pkg::WIDX_W'(bnba_pkg::MAX_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               found_in = 1'b0;
               pos_in   = '0;
               if (req.req_type == bnba_pkg::REQ_LOAD) begin
                  wr.en    = (bnba_pkg::WCNT_W'(req.word_index) <
                              bnba_pkg::WCNT_W'(bnba_pkg::MAX_WORDS));
                  wr.addr  = req.word_index;
                  wr.data  = req.word_data;
                  state_in = ST_DONE;
               end else begin
                  kind_in    = req.req_type;
                  shift_in   = req.start_pos[bnba_pkg::BIDX_W-1:0];
                  first_in   = 1'b1;
                  chk_vld_in = 1'b0;
                  word_in    = start_word;
                  state_in   = (start_word < limit) ? ST_SCAN : ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            // Issue the next read while the previous word is checked.
            rd_en = 1'b1;
            if (word_ff < limit) begin
               chk_vld_in = 1'b1;
               chk_in     = word_ff[bnba_pkg::WIDX_W-1:0];
               word_in    = word_ff + 1'b1;
            end else begin
               chk_vld_in = 1'b0;
            end
            if (chk_vld_ff) begin
               first_in = 1'b0;
               if (hit.hit) begin
                  found_in = 1'b1;
                  pos_in   = bnba_pkg::POS_W'({chk_ff, hit.idx}) + 1'b1;
                  state_in = ST_DONE;
                  if (kind_ff == bnba_pkg::REQ_ALLOC) begin
                     wr.en       = 1'b1;
                     wr.addr     = chk_ff;
                     wr.data     = rd_data | hit.onehot;
                     stat.set_wr = 1'b1;
                  end
               end else if (word_ff >= limit) begin
                  found_in = 1'b0;
                  pos_in   = '0;
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            // Move the answer into the response register once it is free.
            if (!rsp_vld_ff || rsp.ready) begin
               rsp_vld_in   = 1'b1;
               rsp_found_in = found_ff;
               rsp_pos_in   = pos_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      word_ff      <= word_in;
      chk_ff       <= chk_in;
      chk_vld_ff   <= chk_vld_in;
      first_ff     <= first_in;
      shift_ff     <= shift_in;
      kind_ff      <= kind_in;
      found_ff     <= found_in;
      pos_ff       <= pos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   assign ffs_ctl.invert  = (kind_ff != bnba_pkg::REQ_FIND_SET);
   assign ffs_ctl.mask_en = first_ff;
   assign ffs_ctl.shift   = shift_ff;

   assign rsp.valid        = rsp_vld_ff;
   assign rsp.found        = rsp_found_ff;
   assign rsp.bit_position = rsp_pos_ff;

endmodule

### rtl/core/bitmap_next_bit_allocator_unit.sv
// A load, or a start past the words in use, goes from accept straight to the done state; a search
// reads the store word by word (one store word is read per cycle) and checks each in the find-first unit.
// A new request is accepted only after the previous answer has moved into the response register.
// Reset is synchronous; afterwards a clearing pass zeroes every word of the store,
// during which no request is accepted. words_in_use resets to 1024.
module bitmap_next_bit_allocator_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   bnba_req_if.sink                             req,
   bnba_rsp_if.source                           rsp,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [bnba_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [bnba_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [bnba_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);

   `include "bitmap_next_bit_allocator_unit_macros.svh"

   logic [bnba_pkg::CFG_W-1:0]      words_ff, words_in;
   logic [bnba_pkg::WCNT_W-1:0]     limit;
   logic [bnba_pkg::WORD_BITS-1:0]  rd_data;
   logic                            rd_en;
   logic [bnba_pkg::WIDX_W-1:0]     rd_addr;
   bnba_pkg::bnba_wr_type           wr;
   bnba_pkg::bnba_ffs_ctl_type      ffs_ctl;
   bnba_pkg::bnba_hit_type          hit;
   bnba_pkg::bnba_stat_type         stat;
   logic                            csr_wr;

   // Configuration register.
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[2] == bnba_pkg::CSR_IDX_WORDS);

   always_comb begin
      words_in = words_ff;
      if (csr_wr) begin
         words_in = pwdata[bnba_pkg::CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         words_ff <= bnba_pkg::WORDS_RESET;
      end else begin
         words_ff <= words_in;
      end
   end

   assign prdata = (paddr[2] == bnba_pkg::CSR_IDX_WORDS) ?
                   bnba_pkg::CSR_DATA_W'(words_ff) : '0;

   // Search bound, never past the end of the store.
   assign limit = (bnba_pkg::WCNT_W'(words_ff) > bnba_pkg::WCNT_W'(bnba_pkg::MAX_WORDS)) ?
                  bnba_pkg::WCNT_W'(bnba_pkg::MAX_WORDS) : bnba_pkg::WCNT_W'(words_ff);

   bnba_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bnba_ffs u_ffs (
      .data (rd_data),
      .ctl  (ffs_ctl),
      .res  (hit)
   );

   bnba_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .rsp     (rsp),
      .limit   (limit),
      .rd_data (rd_data),
      .hit     (hit),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .wr      (wr),
      .ffs_ctl (ffs_ctl),
      .stat    (stat)
   );

   // The found flag agrees with the reported position.
   `BNBA_ASSERT_IMP(a_found_pos, clock, reset, rsp.valid, (rsp.found == (rsp.bit_position != 16'd0)), "found flag disagrees with bit position")
   // Nothing is accepted or answered while the store is being cleared.
   `BNBA_ASSERT_IMP(a_clear_quiet, clock, reset, stat.clearing, (!req.ready && !rsp.valid), "activity during clearing pass")
   // An allocation write sets exactly one bit that was clear.
   `BNBA_ASSERT_IMP(a_alloc_one, clock, reset, stat.set_wr, ($countones(wr.data ^ rd_data) == 1), "allocation changed other than one bit")
   // One request at a time: after an accept the request side closes.
   `BNBA_ASSERT_NXT(a_one_item, clock, reset, (req.valid && req.ready), !req.ready, "request accepted while busy")

endmodule
